@@ rtl/brt_pkg.sv @@
// Shared constants, types and helpers of the register read transaction unit.
package brt_pkg;

   localparam int PAYLOAD_MAX = 64;
   localparam int RX_BUFFER   = 160;
   localparam int PAYLOAD_AW  = $clog2(PAYLOAD_MAX);
   localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);

   localparam logic [7:0] MARK_START  = 8'hDD;
   localparam logic [7:0] MARK_REQ    = 8'hA5;
   localparam logic [7:0] MARK_END    = 8'h77;
   localparam logic [7:0] STATUS_OK   = 8'h00;
   localparam logic [7:0] HEADER_LEN  = 8'd4;
   localparam logic [7:0] FRAME_MIN   = 8'd7;

   localparam logic [2:0] REQ_LAST = 3'd6;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   localparam logic [2:0] CODE_OK        = 3'd0;
   localparam logic [2:0] CODE_TIMEOUT   = 3'd1;
   localparam logic [2:0] CODE_BAD_FRAME = 3'd2;
   localparam logic [2:0] CODE_WRONG_REG = 3'd3;
   localparam logic [2:0] CODE_BAD_LEN   = 3'd4;
   localparam logic [2:0] CODE_CHECKSUM  = 3'd5;
   localparam logic [2:0] CODE_DEVICE    = 3'd6;

   localparam logic [1:0] CSR_EXP_REG = 2'd0;
   localparam logic [1:0] CSR_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT = 2'd2;
   localparam logic [1:0] CSR_GAP     = 2'd3;

   typedef struct packed {
      logic             start;
      logic [7:0]       reg_num;
      logic             verdict;
      logic [2:0]       code;
      logic [7:0]       dstat;
      logic [LEN_W-1:0] len;
   } cmd_type;

   function automatic logic [7:0] req_byte(input logic [2:0] idx, input logic [7:0] reg_num);
      logic [15:0] chk;
      chk = 16'h0000 - {8'h00, reg_num};
      unique case (idx)
         3'd0:    req_byte = MARK_START;
         3'd1:    req_byte = MARK_REQ;
         3'd2:    req_byte = reg_num;
         3'd3:    req_byte = 8'h00;
         3'd4:    req_byte = chk[15:8];
         3'd5:    req_byte = chk[7:0];
         default: req_byte = MARK_END;
      endcase
   endfunction

endpackage

@@ rtl/bms_register_read_transaction_unit.sv @@
// Top level of the battery monitor register read transaction unit.
// Input channel req_*: tuser carries the function (start, received byte,
// millisecond tick), tdata the received byte. A start item emits seven
// request bytes and arms the receiver; bytes and ticks then build and time
// the response. When the response ends, one verdict item or the payload
// bytes follow on rsp_*, the final one marked by tlast.
// Configuration: csr_we writes register csr_index from csr_wdata at once.
// Flow: a byte or tick that causes no result leaves req_tready high. At a
// frame end the frame checks run on the registered frame state before the
// sequencer loads the first result. Request bytes and verdicts leave at one
// per cycle while the output register is free; each payload byte passes
// through the read and wait states of the registered payload memory read.
// While results are still being emitted req_tready stays low; the last
// result may wait in the output register while the next item is taken.
// A stalled receiver holds the output register and the sequencer.
// Reset disarms the receiver, clears the output and restores the register
// defaults; no memory clearing pass is needed.
module bms_register_read_transaction_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data, code, device_status
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   brt_pkg::cmd_type                cmd;
   logic                            accept;
   logic                            idle;
   logic                            ram_we;
   logic [brt_pkg::PAYLOAD_AW-1:0]  ram_waddr;
   logic [7:0]                      ram_wdata;
   logic                            ram_re;
   logic [brt_pkg::PAYLOAD_AW-1:0]  ram_raddr;
   logic [7:0]                      ram_rdata;

   assign req_tready = idle && !cmd.verdict;
   assign accept     = req_tvalid && req_tready;

   brt_rx u_rx (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .func      (req_tuser),
      .rx_byte   (req_tdata),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .cmd       (cmd)
   );

   brt_payload_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   brt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/brt_payload_ram.sv @@
// Payload byte store: one write port, one registered read port.
module brt_payload_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [brt_pkg::PAYLOAD_AW-1:0]  wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [brt_pkg::PAYLOAD_AW-1:0]  rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [brt_pkg::PAYLOAD_MAX];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/brt_rx.sv @@
// Receiver: configuration registers, frame collection, timers and frame checks.
module brt_rx (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [15:0]                     csr_wdata,
   input  logic                            accept,
   input  logic [1:0]                      func,
   input  logic [7:0]                      rx_byte,
   output logic                            ram_we,
   output logic [brt_pkg::PAYLOAD_AW-1:0]  ram_waddr,
   output logic [7:0]                      ram_wdata,
   output brt_pkg::cmd_type                cmd
);

   logic [7:0]  exp_reg_ff;
   logic [6:0]  limit_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  gap_ff;

   logic        armed_ff, armed_in;
   logic        fin_ff, fin_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  echo_ff, echo_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  tail0_ff, tail0_in;
   logic [7:0]  tail1_ff, tail1_in;
   logic [7:0]  tail2_ff, tail2_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  silence_ff, silence_in;

   logic [7:0]  count_nx;
   logic [7:0]  store_idx;
   logic [6:0]  lim;
   logic [8:0]  frame_len;
   logic [15:0] chk_res;

   assign count_nx  = count_ff + 8'd1;
   assign store_idx = count_ff - brt_pkg::HEADER_LEN;

   always_comb begin
      armed_in   = armed_ff;
      fin_in     = 1'b0;
      count_in   = count_ff;
      first_in   = first_ff;
      echo_in    = echo_ff;
      status_in  = status_ff;
      length_in  = length_ff;
      sum_in     = sum_ff;
      tail0_in   = tail0_ff;
      tail1_in   = tail1_ff;
      tail2_in   = tail2_ff;
      elapsed_in = elapsed_ff;
      silence_in = silence_ff;
      ram_we     = 1'b0;
      ram_waddr  = store_idx[brt_pkg::PAYLOAD_AW-1:0];
      ram_wdata  = rx_byte;
      if (accept) begin
         if (func == brt_pkg::FUNC_START) begin
            armed_in   = 1'b1;
            count_in   = 8'd0;
            first_in   = 8'd0;
            echo_in    = 8'd0;
            status_in  = 8'd0;
            length_in  = 8'd0;
            sum_in     = 16'd0;
            tail0_in   = 8'd0;
            tail1_in   = 8'd0;
            tail2_in   = 8'd0;
            elapsed_in = 16'd0;
            silence_in = 8'd0;
         end else if (armed_ff && func == brt_pkg::FUNC_BYTE) begin
            priority if (count_ff == 8'd0) begin
               first_in = rx_byte;
            end else if (count_ff == 8'd1) begin
               echo_in = rx_byte;
            end else if (count_ff == 8'd2) begin
               status_in = rx_byte;
            end else if (count_ff == 8'd3) begin
               length_in = rx_byte;
            end else begin
               ram_we = (store_idx < 8'(brt_pkg::PAYLOAD_MAX));
            end
            if (count_ff >= 8'd2) begin
               sum_in = sum_ff + {8'h00, rx_byte};
            end
            tail0_in   = tail1_ff;
            tail1_in   = tail2_ff;
            tail2_in   = rx_byte;
            count_in   = count_nx;
            silence_in = 8'd0;
            if ((count_nx >= 8'd2 && rx_byte == brt_pkg::MARK_END) ||
                count_nx >= 8'(brt_pkg::RX_BUFFER)) begin
               fin_in   = 1'b1;
               armed_in = 1'b0;
            end
         end else if (armed_ff && func == brt_pkg::FUNC_TICK) begin
            if (elapsed_ff != 16'hFFFF) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
            if (silence_ff != 8'hFF) begin
               silence_in = silence_ff + 8'd1;
            end
            if (elapsed_in >= timeout_ff ||
                (count_ff != 8'd0 && silence_in > gap_ff)) begin
               fin_in   = 1'b1;
               armed_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_reg_ff <= 8'd3;
         limit_ff   <= 7'd64;
         timeout_ff <= 16'd500;
         gap_ff     <= 8'd40;
         armed_ff   <= 1'b0;
         fin_ff     <= 1'b0;
         count_ff   <= 8'd0;
         first_ff   <= 8'd0;
         echo_ff    <= 8'd0;
         status_ff  <= 8'd0;
         length_ff  <= 8'd0;
         sum_ff     <= 16'd0;
         tail0_ff   <= 8'd0;
         tail1_ff   <= 8'd0;
         tail2_ff   <= 8'd0;
         elapsed_ff <= 16'd0;
         silence_ff <= 8'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               brt_pkg::CSR_EXP_REG: exp_reg_ff <= csr_wdata[7:0];
               brt_pkg::CSR_LIMIT:   limit_ff   <= csr_wdata[6:0];
               brt_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
               brt_pkg::CSR_GAP:     gap_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end
         armed_ff   <= armed_in;
         fin_ff     <= fin_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         echo_ff    <= echo_in;
         status_ff  <= status_in;
         length_ff  <= length_in;
         sum_ff     <= sum_in;
         tail0_ff   <= tail0_in;
         tail1_ff   <= tail1_in;
         tail2_ff   <= tail2_in;
         elapsed_ff <= elapsed_in;
         silence_ff <= silence_in;
      end
   end

   // check the collected frame in the cycle after it ends
   assign lim       = (limit_ff > 7'(brt_pkg::PAYLOAD_MAX)) ? 7'(brt_pkg::PAYLOAD_MAX)
                                                             : limit_ff;
   assign frame_len = {1'b0, brt_pkg::FRAME_MIN} + {1'b0, length_ff};
   assign chk_res   = sum_ff - {8'h00, tail0_ff} - {8'h00, tail1_ff} - {8'h00, tail2_ff}
                      + {tail0_ff, tail1_ff};

   always_comb begin
      cmd         = '0;
      cmd.start   = accept && func == brt_pkg::FUNC_START;
      cmd.reg_num = exp_reg_ff;
      cmd.verdict = fin_ff;
      cmd.len     = length_ff[brt_pkg::LEN_W-1:0];
      cmd.dstat   = status_ff;
      priority if (count_ff == 8'd0) begin
         cmd.code  = brt_pkg::CODE_TIMEOUT;
         cmd.dstat = 8'd0;
      end else if (count_ff < brt_pkg::FRAME_MIN || first_ff != brt_pkg::MARK_START ||
                   tail2_ff != brt_pkg::MARK_END) begin
         cmd.code  = brt_pkg::CODE_BAD_FRAME;
         cmd.dstat = 8'd0;
      end else if (echo_ff != exp_reg_ff) begin
         cmd.code = brt_pkg::CODE_WRONG_REG;
      end else if ({1'b0, count_ff} != frame_len || length_ff > {1'b0, lim}) begin
         cmd.code = brt_pkg::CODE_BAD_LEN;
      end else if (chk_res != 16'd0) begin
         cmd.code = brt_pkg::CODE_CHECKSUM;
      end else if (status_ff != brt_pkg::STATUS_OK) begin
         cmd.code = brt_pkg::CODE_DEVICE;
      end else begin
         cmd.code = brt_pkg::CODE_OK;
      end
   end

`ifndef SYNTH
   a_fin_pulse: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> !fin_ff) else $error("frame end held for two cycles");
   a_fin_disarms: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !armed_ff) else $error("receiver still armed at frame end");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 8'(brt_pkg::RX_BUFFER)) else $error("byte count beyond buffer");
`endif

endmodule

@@ rtl/brt_emit.sv @@
// Result sequencer: request bytes, verdicts and payload drain into the output register.
module brt_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  brt_pkg::cmd_type                cmd,
   output logic                            ram_re,
   output logic [brt_pkg::PAYLOAD_AW-1:0]  ram_raddr,
   input  logic [7:0]                      ram_rdata,
   output logic                            idle,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // data, code, device_status
   output logic [1:0]                      rsp_tuser,  // kind
   output logic                            rsp_tlast
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REQ,
      S_VERD,
      S_RD,
      S_WAIT
   } state_type;

   state_type                       state_ff;
   logic [brt_pkg::PAYLOAD_AW-1:0]  idx_ff;
   logic [brt_pkg::LEN_W-1:0]       len_ff;
   logic [7:0]                      reg_ff;
   logic [2:0]                      code_ff;
   logic [7:0]                      dstat_ff;
   logic                            valid_ff;
   logic [7:0]                      data_ff;
   logic [2:0]                      ocode_ff;
   logic [7:0]                      ostat_ff;
   logic [1:0]                      kind_ff;
   logic                            last_ff;
   logic                            out_free;
   logic [brt_pkg::LEN_W-1:0]       idx_nx;

   assign out_free  = !valid_ff || rsp_tready;
   assign idx_nx    = {1'b0, idx_ff} + 1'b1;
   assign ram_re    = (state_ff == S_RD);
   assign ram_raddr = idx_ff;
   assign idle      = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (valid_ff && rsp_tready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  reg_ff   <= cmd.reg_num;
                  idx_ff   <= '0;
                  state_ff <= S_REQ;
               end else if (cmd.verdict) begin
                  code_ff  <= cmd.code;
                  dstat_ff <= cmd.dstat;
                  len_ff   <= cmd.len;
                  idx_ff   <= '0;
                  if (cmd.code == brt_pkg::CODE_OK && cmd.len != '0) begin
                     state_ff <= S_RD;
                  end else begin
                     state_ff <= S_VERD;
                  end
               end
            end
            S_REQ: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  kind_ff  <= brt_pkg::KIND_TX;
                  data_ff  <= brt_pkg::req_byte(idx_ff[2:0], reg_ff);
                  last_ff  <= 1'b0;
                  ocode_ff <= brt_pkg::CODE_OK;
                  ostat_ff <= 8'd0;
                  if (idx_ff[2:0] == brt_pkg::REQ_LAST) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff <= idx_nx[brt_pkg::PAYLOAD_AW-1:0];
                  end
               end
            end
            S_VERD: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  kind_ff  <= brt_pkg::KIND_VERDICT;
                  data_ff  <= 8'd0;
                  last_ff  <= 1'b1;
                  ocode_ff <= code_ff;
                  ostat_ff <= dstat_ff;
                  state_ff <= S_IDLE;
               end
            end
            S_RD: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  kind_ff  <= brt_pkg::KIND_PAYLOAD;
                  data_ff  <= ram_rdata;
                  last_ff  <= (idx_nx == len_ff);
                  ocode_ff <= brt_pkg::CODE_OK;
                  ostat_ff <= dstat_ff;
                  if (idx_nx == len_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_nx[brt_pkg::PAYLOAD_AW-1:0];
                     state_ff <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, ostat_ff, ocode_ff, data_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == S_IDLE) else $error("start while sequencer busy");
   a_verdict_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.verdict |-> state_ff == S_IDLE) else $error("frame end while sequencer busy");
   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_WAIT) |-> {1'b0, idx_ff} < len_ff)
      else $error("payload read past frame length");
`endif

endmodule

@@ dv/tb_bms_register_read_transaction_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench: directed table of exchanges, then random register reads under several settings.
module tb_bms_register_read_transaction_unit;
   import brt_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int ITEMS_PER_SET = 22;
   localparam int TICK_CAP      = 300;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic [2:0] code;
      logic [7:0] dstat;
   } link_word_t;

   typedef struct {
      logic [1:0] func;
      logic [7:0] rx;
      bit         fixed;
      logic [2:0] code;
      logic [7:0] dstat;
   } script_row_t;

   typedef struct {
      logic [7:0]  exp_reg;
      logic [6:0]  limit;
      logic [15:0] timeout;
      logic [7:0]  gap;
   } setting_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // rx_byte
   logic [1:0]  req_tuser;   // func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // data, code, device_status
   logic [1:0]  rsp_tuser;   // kind
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   bms_register_read_transaction_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // register settings as the block sees them
   logic [7:0]  want_reg       = 8'd3;
   logic [6:0]  len_cap        = 7'd64;
   logic [15:0] total_limit_ms = 16'd500;
   logic [7:0]  quiet_limit_ms = 8'd40;

   // receiver state of the exchange in flight
   bit          listening = 1'b0;
   logic [7:0]  seen_count = 8'd0;
   logic [7:0]  lead_byte = 8'd0;
   logic [7:0]  echo_reg = 8'd0;
   logic [7:0]  dev_status = 8'd0;
   logic [7:0]  len_field = 8'd0;
   logic [15:0] body_sum = 16'd0;
   logic [7:0]  last3 [3] = '{8'd0, 8'd0, 8'd0};
   logic [7:0]  payload_mem [PAYLOAD_MAX];
   logic [15:0] ms_total = 16'd0;
   logic [7:0]  ms_quiet = 8'd0;

   link_word_t  fresh_words [$];
   link_word_t  awaited_words [$];

   int errors = 0;
   int set_items = 0;
   bit sender_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit hold_rsp = 1'b0;

   script_row_t script [26] = '{
      '{FUNC_TICK,   8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'hFF,      1'b0, CODE_OK,        8'h00},
      '{FUNC_UNUSED, 8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_START,  8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_START, 1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_END,   1'b1, CODE_BAD_FRAME, 8'h00},
      '{FUNC_START,  8'hFF,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_START, 1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h03,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_END,   1'b1, CODE_OK,        8'h00},
      '{FUNC_START,  8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_START, 1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h03,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h80,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'hFF,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   8'h80,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_END,   1'b1, CODE_DEVICE,    8'h80},
      '{FUNC_START,  8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_BYTE,   MARK_START, 1'b0, CODE_OK,        8'h00},
      '{FUNC_START,  8'h00,      1'b0, CODE_OK,        8'h00},
      '{FUNC_UNUSED, 8'hFF,      1'b0, CODE_OK,        8'h00}
   };

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic link_word_t make_word(input logic [1:0] kind, input logic [7:0] data,
                                            input logic last, input logic [2:0] code,
                                            input logic [7:0] dstat);
      link_word_t w;
      w.kind  = kind;
      w.data  = data;
      w.last  = last;
      w.code  = code;
      w.dstat = dstat;
      return w;
   endfunction

   task automatic judge_frame();
      int n;
      int len;
      int lim;
      logic [15:0] body;
      logic [15:0] calc;
      logic [15:0] got;
      listening = 1'b0;
      n = int'(seen_count);
      len = int'(len_field);
      lim = (int'(len_cap) > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(len_cap);
      body = body_sum - 16'(last3[0]) - 16'(last3[1]) - 16'(last3[2]);
      calc = 16'h0000 - body;
      got  = {last3[0], last3[1]};
      if (n == 0)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_TIMEOUT, 8'h00));
      else if (n < int'(FRAME_MIN) || lead_byte != MARK_START || last3[2] != MARK_END)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_BAD_FRAME, 8'h00));
      else if (echo_reg != want_reg)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_WRONG_REG, dev_status));
      else if (n != int'(FRAME_MIN) + len || len > lim)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_BAD_LEN, dev_status));
      else if (got != calc)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_CHECKSUM, dev_status));
      else if (dev_status != STATUS_OK)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_DEVICE, dev_status));
      else if (len == 0)
         fresh_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, CODE_OK, dev_status));
      else
         for (int i = 0; i < len; i++)
            fresh_words.push_back(make_word(KIND_PAYLOAD, payload_mem[i], i == len - 1,
                                            CODE_OK, dev_status));
   endtask

   task automatic predict_item(input logic [1:0] f, input logic [7:0] b);
      int idx;
      logic [15:0] chk;
      fresh_words.delete();
      if (f == FUNC_START) begin
         chk = 16'h0000 - {8'h00, want_reg};
         fresh_words.push_back(make_word(KIND_TX, MARK_START, 1'b0, CODE_OK, 8'h00));
         fresh_words.push_back(make_word(KIND_TX, MARK_REQ, 1'b0, CODE_OK, 8'h00));
         fresh_words.push_back(make_word(KIND_TX, want_reg, 1'b0, CODE_OK, 8'h00));
         fresh_words.push_back(make_word(KIND_TX, 8'h00, 1'b0, CODE_OK, 8'h00));
         fresh_words.push_back(make_word(KIND_TX, chk[15:8], 1'b0, CODE_OK, 8'h00));
         fresh_words.push_back(make_word(KIND_TX, chk[7:0], 1'b0, CODE_OK, 8'h00));
         fresh_words.push_back(make_word(KIND_TX, MARK_END, 1'b0, CODE_OK, 8'h00));
         seen_count = 8'd0;
         lead_byte  = 8'd0;
         echo_reg   = 8'd0;
         dev_status = 8'd0;
         len_field  = 8'd0;
         body_sum   = 16'd0;
         last3      = '{8'd0, 8'd0, 8'd0};
         ms_total   = 16'd0;
         ms_quiet   = 8'd0;
         listening  = 1'b1;
      end else if (listening && f == FUNC_BYTE) begin
         idx = int'(seen_count);
         case (idx)
            0: lead_byte = b;
            1: echo_reg = b;
            2: dev_status = b;
            3: len_field = b;
            default: begin
               if (idx < int'(HEADER_LEN) + PAYLOAD_MAX)
                  payload_mem[idx - int'(HEADER_LEN)] = b;
            end
         endcase
         if (idx >= 2) body_sum = body_sum + 16'(b);
         last3[0] = last3[1];
         last3[1] = last3[2];
         last3[2] = b;
         seen_count = 8'(idx + 1);
         ms_quiet = 8'd0;
         if ((seen_count >= 8'd2 && b == MARK_END) || int'(seen_count) >= RX_BUFFER)
            judge_frame();
      end else if (listening && f == FUNC_TICK) begin
         if (ms_total != 16'hFFFF) ms_total = ms_total + 16'd1;
         if (ms_quiet != 8'hFF) ms_quiet = ms_quiet + 8'd1;
         if (ms_total >= total_limit_ms)
            judge_frame();
         else if (seen_count != 8'd0 && ms_quiet > quiet_limit_ms)
            judge_frame();
      end
   endtask

   function automatic int sender_gap();
      int r;
      if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
      if (sender_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [1:0] f, input logic [7:0] b, input bit fixed = 1'b0,
                            input logic [2:0] code = CODE_OK, input logic [7:0] dstat = 8'h00);
      int pause;
      pause = sender_gap();
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (f == FUNC_START || (listening && f == FUNC_BYTE)) set_items++;
      predict_item(f, b);
      if (fixed)
         awaited_words.push_back(make_word(KIND_VERDICT, 8'h00, 1'b1, code, dstat));
      else
         foreach (fresh_words[i]) awaited_words.push_back(fresh_words[i]);
      @(negedge clock);
   endtask

   task automatic settle(input int cycles);
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_setting(input setting_t s);
      csr_we    <= 1'b1;
      csr_index <= CSR_EXP_REG;
      csr_wdata <= {8'h00, s.exp_reg};
      want_reg = s.exp_reg;
      @(negedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= {9'h000, s.limit};
      len_cap = s.limit;
      @(negedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= s.timeout;
      total_limit_ms = s.timeout;
      @(negedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= {8'h00, s.gap};
      quiet_limit_ms = s.gap;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_exchange();
      int pick;
      int len;
      int fault;
      int spins;
      logic [7:0] frame_q [$];
      logic [7:0] b;
      logic [15:0] sum;
      logic [15:0] chk;
      pick = $urandom_range(0, 99);
      if (pick >= 80 && pick < 90) begin
         repeat ($urandom_range(3, 10))
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
         send_item(FUNC_START, 8'($urandom_range(0, 255)));
         if (pick < 62) begin
            fault = $urandom_range(0, 99);
            if (fault < 70) len = $urandom_range(0, 8);
            else if (fault < 92) len = $urandom_range(9, 40);
            else len = PAYLOAD_MAX;
            fault = $urandom_range(0, 11);
            frame_q.push_back(fault == 0 ? 8'($urandom_range(0, 255)) : MARK_START);
            frame_q.push_back(fault == 1 ? 8'($urandom_range(0, 255)) : want_reg);
            frame_q.push_back(fault == 2 ? 8'($urandom_range(0, 255)) : STATUS_OK);
            frame_q.push_back(fault == 3 ? 8'(len + $urandom_range(1, 3)) : 8'(len));
            repeat (len) begin
               b = 8'($urandom_range(0, 255));
               if (b == MARK_END) b = ~b;
               frame_q.push_back(b);
            end
            sum = 16'h0000;
            for (int i = 2; i < frame_q.size(); i++) sum = sum + 16'(frame_q[i]);
            chk = 16'h0000 - sum;
            if (fault == 4) chk = chk ^ (16'h0001 << $urandom_range(0, 15));
            frame_q.push_back(chk[15:8]);
            frame_q.push_back(chk[7:0]);
            frame_q.push_back(MARK_END);
         end else if (pick < 72) begin
            frame_q.push_back(MARK_START);
            repeat ($urandom_range(0, 5)) frame_q.push_back(8'($urandom_range(0, 255)));
         end else if (pick >= 90) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
         end
         foreach (frame_q[i]) begin
            if ($urandom_range(0, 9) == 0) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
            send_item(FUNC_BYTE, frame_q[i]);
         end
         spins = 0;
         if (pick >= 62)
            while (listening && spins < TICK_CAP) begin
               send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
               spins++;
            end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 40) $display("%0t ns: %s mismatch: got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      link_word_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            report_mismatch("unexpected item data", int'(rsp_tdata[7:0]), 0);
         end else begin
            want = awaited_words.pop_front();
            if (rsp_tuser !== want.kind) report_mismatch("kind", int'(rsp_tuser), int'(want.kind));
            if (rsp_tdata[7:0] !== want.data)
               report_mismatch("data", int'(rsp_tdata[7:0]), int'(want.data));
            if (rsp_tlast !== want.last) report_mismatch("last", int'(rsp_tlast), int'(want.last));
            if (rsp_tdata[10:8] !== want.code)
               report_mismatch("code", int'(rsp_tdata[10:8]), int'(want.code));
            if (rsp_tdata[18:11] !== want.dstat)
               report_mismatch("device status", int'(rsp_tdata[18:11]), int'(want.dstat));
         end
      end
   end

   initial begin
      int r;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (r > 0) begin
            rsp_tready <= 1'b0;
            r--;
         end else begin
            rsp_tready <= 1'b1;
            if (!rx_calm) begin
               r = $urandom_range(0, 99);
               if (r < 20) r = $urandom_range(1, 3);
               else if (r < 23) r = $urandom_range(15, 40);
               else r = 0;
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      setting_t plan [5];
      logic [7:0] b;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = FUNC_TICK;
      csr_we     = 1'b0;
      csr_index  = CSR_EXP_REG;
      csr_wdata  = 16'h0000;
      plan[0] = '{8'd3, 7'd64, 16'd500, 8'd40};
      plan[1] = '{8'h00, 7'd0, 16'd1, 8'd1};
      plan[2] = '{8'hFF, 7'd127, 16'hFFFF, 8'hFF};
      plan[3] = '{8'h5A, 7'd10, 16'd0, 8'd0};
      plan[4] = '{8'($urandom_range(0, 255)), 7'($urandom_range(0, 64)),
                  16'($urandom_range(2, 300)), 8'($urandom_range(1, 60))};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i])
         send_item(script[i].func, script[i].rx, script[i].fixed, script[i].code, script[i].dstat);

      foreach (plan[p]) begin
         if (p > 0) begin
            settle(8);
            write_setting(plan[p]);
         end
         set_items = 0;
         if (p == 0) begin
            hold_rsp = 1'b1;
            run_exchange();
            settle(1);
         end
         while (set_items < ITEMS_PER_SET) run_exchange();
         if (p == 2) begin
            // fill the receive buffer without an end marker
            send_item(FUNC_START, 8'h00);
            send_item(FUNC_BYTE, MARK_START);
            repeat (RX_BUFFER - 1) begin
               b = 8'($urandom_range(0, 255));
               if (b == MARK_END) b = ~b;
               send_item(FUNC_BYTE, b);
            end
         end
      end

      settle(20);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/brt_pkg.sv
rtl/brt_payload_ram.sv
rtl/brt_rx.sv
rtl/brt_emit.sv
rtl/bms_register_read_transaction_unit.sv
dv/tb_bms_register_read_transaction_unit.sv
